// File: rtl/lcd_serial_frame_transmitter_assert.svh
// Assertion macros for the LCD serial frame transmitter.
// Used by lsft_ctrl; no other dependencies.
`ifndef LCD_SERIAL_FRAME_TRANSMITTER_ASSERT_SVH
`define LCD_SERIAL_FRAME_TRANSMITTER_ASSERT_SVH

`ifndef SYNTH
`define LSFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSFT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LSFT_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSFT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: rtl/lsft_pkg.sv
// Shared types, codes and frame helpers for the LCD serial frame transmitter.
// No dependencies.
package lsft_pkg;

    localparam int FRAME_BITS = 24;
    localparam int CNT_W      = $clog2(FRAME_BITS);

    localparam logic [7:0] SYNC_COMMAND = 8'hF8;
    localparam logic [7:0] SYNC_DATA    = 8'hFA;
    localparam logic [7:0] ADDR_BASE    = 8'h80;
    localparam logic [7:0] LOWER_HALF   = 8'd8;

    typedef enum logic [1:0] {
        CMD_RAW_COMMAND = 2'd0,
        CMD_RAW_DATA    = 2'd1,
        CMD_TEXT_ADDR   = 2'd2,
        CMD_GFX_ADDR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME0,
        ST_FRAME1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture request, load first frame
        logic load2;  // load second graphic frame
        logic shift;  // advance one bit
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bit_done;    // current bit is the frame's last
        logic two_frames;  // request needs a second frame
    } t_dp_stat;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'h90;
            2'd2:    base = 8'h88;
            default: base = 8'h98;
        endcase
        return base;
    endfunction

    function automatic logic [FRAME_BITS-1:0] make_frame(input logic is_data,
                                                        input logic [7:0] value);
        logic [7:0] sync;
        sync = is_data ? SYNC_DATA : SYNC_COMMAND;
        return {sync, value[7:4], 4'b0000, value[3:0], 4'b0000};
    endfunction

endpackage

// File: rtl/lsft_datapath.sv
// Datapath: address formation, frame shift register and bit counter.
// Depends on lsft_pkg.
module lsft_datapath
    import lsft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd_bus,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic [1:0] i_text_row,
    input  logic [3:0] i_text_col,
    input  logic [6:0] i_pixel_x,
    input  logic [5:0] i_pixel_y,
    output t_dp_stat   o_stat,
    output logic       o_sid_bit
);

    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [7:0]            r_second, n_second;
    logic                  r_two, n_two;

    logic [7:0] first_value;
    logic       first_is_data;
    logic [7:0] x_addr;

    assign x_addr = ADDR_BASE + {5'b0, i_pixel_x[6:4]}
                  + (i_pixel_y[5] ? LOWER_HALF : 8'd0);

    always_comb begin
        first_is_data = 1'b0;
        unique case (t_cmd'(i_cmd))
            CMD_RAW_COMMAND: first_value = i_byte_value;
            CMD_RAW_DATA: begin
                first_value   = i_byte_value;
                first_is_data = 1'b1;
            end
            CMD_TEXT_ADDR:   first_value = row_base(i_text_row) + {4'b0, i_text_col};
            default:         first_value = ADDR_BASE + {3'b0, i_pixel_y[4:0]};
        endcase
    end

    always_comb begin
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_second = r_second;
        n_two    = r_two;
        if (i_cmd_bus.load) begin
            n_shift  = make_frame(first_is_data, first_value);
            n_cnt    = '0;
            n_second = x_addr;
            n_two    = (t_cmd'(i_cmd) == CMD_GFX_ADDR);
        end else if (i_cmd_bus.load2) begin
            n_shift = make_frame(1'b0, r_second);
            n_cnt   = '0;
        end else if (i_cmd_bus.shift) begin
            n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_two <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_two <= n_two;
        end
        r_shift  <= n_shift;
        r_second <= n_second;
    end

    assign o_stat.bit_done   = (r_cnt == CNT_W'(FRAME_BITS - 1));
    assign o_stat.two_frames = r_two;
    assign o_sid_bit         = r_shift[FRAME_BITS-1];

endmodule

// File: rtl/lsft_ctrl.sv
// Controller: frame sequencing, handshake and word strobes.
// Depends on lsft_pkg and lcd_serial_frame_transmitter_assert.svh.
`include "lcd_serial_frame_transmitter_assert.svh"
module lsft_ctrl
    import lsft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd_bus,
    output logic     o_valid,
    output logic     o_last_bit
);

    t_state r_state, n_state;
    logic   accept;
    logic   last;

    // final bit of the whole request
    assign last = i_stat.bit_done
                && ((r_state == ST_FRAME1) || ((r_state == ST_FRAME0) && !i_stat.two_frames));
    assign busy   = (r_state != ST_IDLE) && !last;
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_FRAME0;
            end
            ST_FRAME0: begin
                if (i_stat.bit_done) begin
                    if (i_stat.two_frames) n_state = ST_FRAME1;
                    else if (accept)       n_state = ST_FRAME0;
                    else                   n_state = ST_IDLE;
                end
            end
            ST_FRAME1: begin
                if (i_stat.bit_done) n_state = accept ? ST_FRAME0 : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_bus  = '0;
        o_valid    = 1'b0;
        o_last_bit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_bus.load = accept;
            end
            ST_FRAME0: begin
                o_valid         = 1'b1;
                o_last_bit      = last;
                o_cmd_bus.load  = accept;
                o_cmd_bus.load2 = i_stat.bit_done && i_stat.two_frames;
                o_cmd_bus.shift = 1'b1;
            end
            ST_FRAME1: begin
                o_valid         = 1'b1;
                o_last_bit      = last;
                o_cmd_bus.load  = accept;
                o_cmd_bus.shift = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LSFT_ASSERT(a_accept_sends, i_clk, i_rst_n, accept |=> o_valid, "accepted word sends no bit")
    `LSFT_ASSERT(a_gfx_second, i_clk, i_rst_n,
        (r_state == ST_FRAME0 && i_stat.bit_done && i_stat.two_frames) |=> (r_state == ST_FRAME1),
        "graphic request lost second frame")
    `LSFT_NEVER(a_busy_idle, i_clk, i_rst_n, busy && (r_state == ST_IDLE), "busy while idle")
    `LSFT_NEVER(a_load_while_busy, i_clk, i_rst_n, o_cmd_bus.load && busy,
        "request loaded while busy")

endmodule

// File: rtl/lcd_serial_frame_transmitter.sv
// Channel     Signals                                   Handshake
// request     i_cmd i_byte_value i_text_row i_text_col  start & !busy
//             i_pixel_x i_pixel_y
// bit stream  o_sid_bit o_last_bit                      o_valid per bit
//
// Raw and text requests send one frame, graphic requests two: one bit per clock
// from the 24-bit frame shift register. busy drops on the final bit, so a new
// request taken then streams with no gap. Synchronous active-low reset returns
// the sequencer to idle; there is no clearing pass. The receiver cannot stall.
// Top level: joins lsft_ctrl and lsft_datapath; uses lsft_pkg.
module lcd_serial_frame_transmitter
    import lsft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic [1:0] i_text_row,
    input  logic [3:0] i_text_col,
    input  logic [6:0] i_pixel_x,
    input  logic [5:0] i_pixel_y,
    output logic       o_valid,
    output logic       o_sid_bit,
    output logic       o_last_bit
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lsft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_stat     (dp_stat),
        .o_cmd_bus  (dp_cmd),
        .o_valid    (o_valid),
        .o_last_bit (o_last_bit)
    );

    lsft_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_bus    (dp_cmd),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .i_text_row   (i_text_row),
        .i_text_col   (i_text_col),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_stat       (dp_stat),
        .o_sid_bit    (o_sid_bit)
    );

endmodule

// File: test/lcd_serial_frame_transmitter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lcd_serial_frame_transmitter: random and directed requests,
// each serial bit checked against a predicted stream. Uses lsft_pkg from rtl.

typedef struct packed {
    logic sid_bit;
    logic last_bit;
} t_sid_word;

class sid_stream_scoreboard;
    t_sid_word   expected_bits[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Queue one 24-bit frame, MSB first; only the stream's final bit carries last_bit.
    function void push_frame(bit is_data, logic [7:0] value, bit ends_stream);
        logic [23:0] frame;
        t_sid_word   word;
        frame = {(is_data ? lsft_pkg::SYNC_DATA : lsft_pkg::SYNC_COMMAND),
                 value[7:4], 4'b0000, value[3:0], 4'b0000};
        for (int i = 23; i >= 0; i--) begin
            word.sid_bit  = frame[i];
            word.last_bit = ends_stream && (i == 0);
            expected_bits.push_back(word);
        end
    endfunction

    function void note_request(lsft_pkg::t_cmd cmd, logic [7:0] byte_value,
                               logic [1:0] text_row, logic [3:0] text_col,
                               logic [6:0] pixel_x, logic [5:0] pixel_y);
        logic [7:0] row_addr;
        logic [7:0] x_addr;
        case (cmd)
            lsft_pkg::CMD_RAW_COMMAND: push_frame(1'b0, byte_value, 1'b1);
            lsft_pkg::CMD_RAW_DATA:    push_frame(1'b1, byte_value, 1'b1);
            lsft_pkg::CMD_TEXT_ADDR: begin
                case (text_row)
                    2'd0:    row_addr = 8'h80;
                    2'd1:    row_addr = 8'h90;
                    2'd2:    row_addr = 8'h88;
                    default: row_addr = 8'h98;
                endcase
                push_frame(1'b0, row_addr + {4'b0000, text_col}, 1'b1);
            end
            default: begin
                // y row first, then x word; lower half of the panel adds 8
                x_addr = lsft_pkg::ADDR_BASE + {5'b00000, pixel_x[6:4]}
                         + (pixel_y[5] ? lsft_pkg::LOWER_HALF : 8'd0);
                push_frame(1'b0, lsft_pkg::ADDR_BASE + {3'b000, pixel_y[4:0]}, 1'b0);
                push_frame(1'b0, x_addr, 1'b1);
            end
        endcase
    endfunction

    function void check_bit(logic sid_bit, logic last_bit);
        t_sid_word want;
        if (expected_bits.size() == 0) begin
            $error("unexpected word: o_sid_bit %0b, o_last_bit %0b", sid_bit, last_bit);
            mismatches++;
            return;
        end
        want = expected_bits.pop_front();
        if (sid_bit !== want.sid_bit) begin
            $error("o_sid_bit: expected %0b, actual %0b", want.sid_bit, sid_bit);
            mismatches++;
        end
        if (last_bit !== want.last_bit) begin
            $error("o_last_bit: expected %0b, actual %0b", want.last_bit, last_bit);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_bits.size();
    endfunction
endclass

module lcd_serial_frame_transmitter_test;
    import lsft_pkg::*;

    localparam int RANDOM_ITEMS   = 261;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 60;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       start        = 1'b0;
    t_cmd       i_cmd        = CMD_RAW_COMMAND;
    logic [7:0] i_byte_value = 8'd0;
    logic [1:0] i_text_row   = 2'd0;
    logic [3:0] i_text_col   = 4'd0;
    logic [6:0] i_pixel_x    = 7'd0;
    logic [5:0] i_pixel_y    = 6'd0;
    logic       busy;
    logic       o_valid;
    logic       o_sid_bit;
    logic       o_last_bit;

    int unsigned          stall_cycles = 0;
    sid_stream_scoreboard sb = new();

    lcd_serial_frame_transmitter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .i_text_row   (i_text_row),
        .i_text_col   (i_text_col),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_valid      (o_valid),
        .o_sid_bit    (o_sid_bit),
        .o_last_bit   (o_last_bit)
    );

    always #4 i_clk = ~i_clk;

    // Check the retiring word before noting a new request, as the stream is FIFO.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_bit(o_sid_bit, o_last_bit);
            if (start && !busy)
                sb.note_request(i_cmd, i_byte_value, i_text_row, i_text_col,
                                i_pixel_x, i_pixel_y);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one request and hold it until taken; start stays high on return.
    task automatic send_request(t_cmd cmd, logic [7:0] byte_value, logic [1:0] text_row,
                                logic [3:0] text_col, logic [6:0] pixel_x,
                                logic [5:0] pixel_y);
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_byte_value <= byte_value;
        i_text_row   <= text_row;
        i_text_col   <= text_col;
        i_pixel_x    <= pixel_x;
        i_pixel_y    <= pixel_y;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_raw(bit is_data, logic [7:0] value);
        send_request(is_data ? CMD_RAW_DATA : CMD_RAW_COMMAND, value, 2'($urandom()),
                     4'($urandom()), 7'($urandom()), 6'($urandom()));
    endtask

    task automatic send_text(logic [1:0] text_row, logic [3:0] text_col);
        send_request(CMD_TEXT_ADDR, 8'($urandom()), text_row, text_col, 7'($urandom()),
                     6'($urandom()));
    endtask

    task automatic send_gfx(logic [6:0] pixel_x, logic [5:0] pixel_y);
        send_request(CMD_GFX_ADDR, 8'($urandom()), 2'($urandom()), 4'($urandom()),
                     pixel_x, pixel_y);
    endtask

    // Drop start and scramble the idle payload for a pause of length n.
    task automatic pause(int unsigned n);
        if (n > 0) begin
            start        <= 1'b0;
            i_cmd        <= t_cmd'($urandom_range(0, 3));
            i_byte_value <= 8'($urandom());
            i_text_row   <= 2'($urandom());
            i_text_col   <= 4'($urandom());
            i_pixel_x    <= 7'($urandom());
            i_pixel_y    <= 6'($urandom());
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned next_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 30);
        else
            return $urandom_range(40, 80);
    endfunction

    initial begin
        bit back_to_back;
        back_to_back = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, every command, row bases, panel halves
        send_raw(1'b0, 8'h00);          pause(next_gap());
        send_raw(1'b0, 8'hFF);          pause(next_gap());
        send_raw(1'b0, 8'h5A);          pause(next_gap());
        send_raw(1'b1, 8'h00);          pause(next_gap());
        send_raw(1'b1, 8'hFF);          pause(next_gap());
        send_raw(1'b1, 8'hA5);          pause(next_gap());
        send_text(2'd0, 4'd0);          pause(next_gap());
        send_text(2'd0, 4'd15);         pause(next_gap());
        send_text(2'd1, 4'd15);         pause(next_gap());
        send_text(2'd2, 4'd7);          pause(next_gap());
        send_text(2'd3, 4'd0);          pause(next_gap());
        send_text(2'd3, 4'd15);         pause(next_gap());
        send_gfx(7'd0, 6'd0);           pause(next_gap());
        send_gfx(7'd127, 6'd63);        pause(next_gap());
        send_gfx(7'd15, 6'd31);         pause(next_gap());
        send_gfx(7'd16, 6'd32);         pause(next_gap());
        send_gfx(7'd127, 6'd0);         pause(next_gap());
        send_gfx(7'd0, 6'd63);          pause(next_gap());
        send_gfx(7'd64, 6'd33);         pause(next_gap());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate stretches of back-to-back words with gapped ones
            if (n % 40 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            send_request(t_cmd'($urandom_range(0, 3)), 8'($urandom()), 2'($urandom()),
                         4'($urandom()), 7'($urandom()), 6'($urandom()));
            if (!back_to_back)
                pause(next_gap());
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/lsft_pkg.sv
rtl/lsft_datapath.sv
rtl/lsft_ctrl.sv
rtl/lcd_serial_frame_transmitter.sv
test/lcd_serial_frame_transmitter_test.sv
